[rtl/trackpad_glide_mouse_core_macros.svh]
// Assertion macros for the trackpad glide mouse checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TRACKPAD_GLIDE_MOUSE_CORE_MACROS_SVH
`define TRACKPAD_GLIDE_MOUSE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TGM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tgm assertion failed");

// Consequent must hold in the cycle after the antecedent
`define TGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tgm assertion failed");

`endif

[rtl/tgm_pkg.sv]
// Shared types and constants for the trackpad glide mouse core.
// No dependencies; used by every module of the block.
package tgm_pkg;

  // Field and state widths
  localparam int POS_W   = 16;
  localparam int BTN_W   = 2;
  localparam int MOVE_W  = 8;
  localparam int VEL_W   = 40;
  localparam int FRAC_V  = 8;
  localparam int CARRY_W = 17;
  localparam int FRAC_C  = 16;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_BIT = 2;
  localparam int SPD_W       = 8;
  localparam int FRIC_W      = 7;
  localparam logic [SPD_W-1:0]  SPD_RESET  = 8'd10;
  localparam logic [FRIC_W-1:0] FRIC_RESET = 7'd90;
  localparam logic [FRIC_W-1:0] FRIC_MAX   = 7'd100;

  // Shared divider: 48-bit dividend, 12-bit divisor, 4 quotient bits a cycle
  localparam int DIV_NUM_W     = VEL_W + FRAC_V;
  localparam int DIV_DEN_W     = 12;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = DIV_NUM_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam logic [DIV_DEN_W-1:0] DECAY_DEN = 12'd100;

  // Quotient plus carry, and its whole part
  localparam int T_W     = DIV_NUM_W;
  localparam int WHOLE_W = T_W - FRAC_C;
  localparam int MUL_W   = VEL_W + FRIC_W;
  localparam int MOVE_LIMIT = 127;
  localparam logic signed [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(MOVE_LIMIT);
  localparam logic signed [WHOLE_W-1:0] WHOLE_MIN = -WHOLE_MAX;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic {
    REG_SPEED_DIV = 1'b0,
    REG_FRICTION  = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VEL,
    S_QX_GO,
    S_QX_RUN,
    S_QX_FIN,
    S_QY_GO,
    S_QY_RUN,
    S_QY_FIN,
    S_MX,
    S_DX_GO,
    S_DX_RUN,
    S_MY,
    S_DY_GO,
    S_DY_RUN,
    S_EMIT
  } state_e;

  // Settings as the datapath needs them
  typedef struct packed {
    logic [DIV_DEN_W-1:0] div10;
    logic [FRIC_W-1:0]    fric;
  } cfg_t;

endpackage

[rtl/tgm_cfg.sv]
// APB register file for speed divisor and friction percent.
// Depends on tgm_pkg; feeds the core with clamped, scaled settings.
module tgm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgm_pkg::PADDR_W-1:0]  paddr,
  input  logic [tgm_pkg::PDATA_W-1:0]  pwdata,
  output logic [tgm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output tgm_pkg::cfg_t                cfg_o
);
  import tgm_pkg::*;

  logic [SPD_W-1:0]  spd_q;
  logic [FRIC_W-1:0] fric_q;
  logic [SPD_W-1:0]  spd_eff;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[REG_IDX_BIT]);

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_q  <= SPD_RESET;
      fric_q <= FRIC_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SPEED_DIV: spd_q  <= pwdata[SPD_W-1:0];
        REG_FRICTION:  fric_q <= pwdata[FRIC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_SPEED_DIV: prdata = PDATA_W'(spd_q);
      REG_FRICTION:  prdata = PDATA_W'(fric_q);
      default:       prdata = '0;
    endcase
  end

  // Zero divisor acts as one; divisor scaled by ten as 8x + 2x
  assign spd_eff     = (spd_q == '0) ? SPD_W'(1) : spd_q;
  assign cfg_o.div10 = (DIV_DEN_W'(spd_eff) << 3) + (DIV_DEN_W'(spd_eff) << 1);
  // Friction above 100 gives no gain
  assign cfg_o.fric  = (fric_q > FRIC_MAX) ? FRIC_MAX : fric_q;

endmodule

[rtl/tgm_div.sv]
// Shared unsigned radix-16 restoring divider, four quotient bits a cycle.
// Depends on tgm_pkg for widths and step count.
module tgm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tgm_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [tgm_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [tgm_pkg::DIV_NUM_W-1:0]  quo_o
);
  import tgm_pkg::*;

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // One step: shift in four dividend bits, trial-subtract after each
  logic [DIV_DEN_W-1:0] r;
  logic [DIV_DEN_W:0]   r_sh;
  logic [DIV_NUM_W-1:0] n;

  always_comb begin
    r    = rem_q;
    n    = num_q;
    r_sh = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r_sh = {r, n[DIV_NUM_W-1]};
      n    = {n[DIV_NUM_W-2:0], 1'b0};
      if (r_sh >= {1'b0, den_q}) begin
        r_sh = r_sh - {1'b0, den_q};
        n[0] = 1'b1;
      end
      r = r_sh[DIV_DEN_W-1:0];
    end
    rem_d = r;
    num_d = n;
  end

  // Step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out as the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

[rtl/trackpad_glide_mouse_core.sv]
// Top level of the trackpad glide mouse: sequencer and datapath around the
// shared divider. Depends on tgm_pkg, tgm_cfg and tgm_div.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  sample  | in_valid_i, in_stall_o, pad_* , other_click | in
//  report  | out_valid_o, out_stall_i, mouse_buttons_o,  | out
//          | move_x_o, move_y_o                          |
//  config  | psel, penable, pwrite, paddr, pwdata,       | in/out
//          | prdata, pready                              |
//
// Each sample makes four passes through the shared divider (12 steps each,
// with set-up and hand-off states around them) plus velocity update, report
// and idle states; no new input transfer is taken until the core is idle.
// Reset clears velocities, carries, last position and last buttons.
// The report register frees the input side; a stalled report only holds the
// core in its report cycle when the next report is ready to go.
module trackpad_glide_mouse_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tgm_pkg::PADDR_W-1:0]         paddr,
  input  logic [tgm_pkg::PDATA_W-1:0]         pwdata,
  output logic [tgm_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pad_touch_i,
  input  logic signed [tgm_pkg::POS_W-1:0]    pad_x_i,
  input  logic signed [tgm_pkg::POS_W-1:0]    pad_y_i,
  input  logic                                pad_click_i,
  input  logic                                other_click_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tgm_pkg::BTN_W-1:0]           mouse_buttons_o,
  output logic signed [tgm_pkg::MOVE_W-1:0]   move_x_o,
  output logic signed [tgm_pkg::MOVE_W-1:0]   move_y_o
);
  import tgm_pkg::*;

  // Saturating velocity update by a position change in Q.8
  function automatic logic signed [VEL_W-1:0] vel_add(
    input logic signed [VEL_W-1:0] v,
    input logic signed [POS_W-1:0] p,
    input logic signed [POS_W-1:0] last
  );
    logic signed [POS_W:0] d;
    logic signed [VEL_W:0] s;
    logic signed [VEL_W-1:0] res;
    d = {p[POS_W-1], p} - {last[POS_W-1], last};
    s = {v[VEL_W-1], v}
        + {{(VEL_W-POS_W-FRAC_V){d[POS_W]}}, d, {FRAC_V{1'b0}}};
    if (s[VEL_W] != s[VEL_W-1]) begin
      res = s[VEL_W] ? VEL_MIN : VEL_MAX;
    end else begin
      res = s[VEL_W-1:0];
    end
    return res;
  endfunction

  cfg_t cfg;

  tgm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  // Sample held for the duration of the work
  logic                     touch_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic [BTN_W-1:0]         btn_q;

  // Persistent state
  logic signed [POS_W-1:0]   last_x_q, last_y_q;
  logic                      was_touch_q;
  logic signed [VEL_W-1:0]   vel_x_q, vel_y_q;
  logic signed [CARRY_W-1:0] carry_x_q, carry_y_q;
  logic [BTN_W-1:0]          last_btn_q;

  // Intermediate results
  logic signed [T_W-1:0]     t_q;
  logic [DIV_NUM_W-1:0]      prod_q;
  logic signed [MOVE_W-1:0]  mvx_q, mvy_q;

  // Report register
  logic                      out_valid_q;
  logic [BTN_W-1:0]          out_btn_q;
  logic signed [MOVE_W-1:0]  out_x_q, out_y_q;

  // Sequencer outputs
  logic axis_y, div_start, use_decay, out_load;

  // Divider connection
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] quo;
  logic                 div_done;

  tgm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Axis selection and magnitude of the velocity in use
  logic signed [VEL_W-1:0]   vel_sel;
  logic                      vel_neg;
  logic [VEL_W-1:0]          vel_abs;
  logic signed [CARRY_W-1:0] carry_sel;

  assign vel_sel   = axis_y ? vel_y_q : vel_x_q;
  assign vel_neg   = vel_sel[VEL_W-1];
  assign vel_abs   = vel_neg ? (~vel_sel + VEL_W'(1)) : vel_sel;
  assign carry_sel = axis_y ? carry_y_q : carry_x_q;

  assign div_num = use_decay ? prod_q : {vel_abs, {FRAC_V{1'b0}}};
  assign div_den = use_decay ? DECAY_DEN : cfg.div10;

  // Signed quotient plus carry; Y quotient is negated
  logic                  q_sub;
  logic signed [T_W-1:0] carry_ext;
  logic signed [T_W-1:0] t_next;

  assign q_sub     = axis_y ? ~vel_neg : vel_neg;
  assign carry_ext = {{(T_W-CARRY_W){carry_sel[CARRY_W-1]}}, carry_sel};
  assign t_next    = q_sub ? (carry_ext - $signed(quo)) : (carry_ext + $signed(quo));

  // Whole part truncated toward zero, remainder keeps the sign of t
  logic [FRAC_C-1:0]           frac;
  logic                        t_inc;
  logic signed [WHOLE_W-1:0]   whole;
  logic signed [CARRY_W-1:0]   carry_new;
  logic signed [MOVE_W-1:0]    move_new;

  assign frac      = t_q[FRAC_C-1:0];
  assign t_inc     = t_q[T_W-1] && (frac != '0);
  assign whole     = $signed(t_q[T_W-1:FRAC_C]) + $signed({{(WHOLE_W-1){1'b0}}, t_inc});
  assign carry_new = {t_inc, frac};

  always_comb begin
    if (whole > WHOLE_MAX) begin
      move_new = MOVE_W'(WHOLE_MAX);
    end else if (whole < WHOLE_MIN) begin
      move_new = MOVE_W'(WHOLE_MIN);
    end else begin
      move_new = whole[MOVE_W-1:0];
    end
  end

  // Friction product and decayed velocity
  logic [MUL_W-1:0]        mul_res;
  logic [VEL_W-1:0]        dec_mag;
  logic signed [VEL_W-1:0] vel_decay;

  assign mul_res = MUL_W'(vel_abs) * MUL_W'(cfg.fric);
  assign dec_mag = quo[VEL_W-1:0];

  always_comb begin
    if (quo[DIV_NUM_W-1:FRAC_V] == '0) begin
      vel_decay = '0;
    end else if (vel_neg) begin
      vel_decay = ~dec_mag + VEL_W'(1);
    end else begin
      vel_decay = dec_mag;
    end
  end

  // Report decision
  logic report, out_free;

  assign report   = (mvx_q != '0) || (mvy_q != '0) || (btn_q != last_btn_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and sequencer controls
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    axis_y     = 1'b0;
    div_start  = 1'b0;
    use_decay  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = S_VEL;
      end
      S_VEL:    state_d = S_QX_GO;
      S_QX_GO: begin
        div_start = 1'b1;
        state_d   = S_QX_RUN;
      end
      S_QX_RUN: if (div_done) state_d = S_QX_FIN;
      S_QX_FIN: state_d = S_QY_GO;
      S_QY_GO: begin
        axis_y    = 1'b1;
        div_start = 1'b1;
        state_d   = S_QY_RUN;
      end
      S_QY_RUN: begin
        axis_y = 1'b1;
        if (div_done) state_d = S_QY_FIN;
      end
      S_QY_FIN: begin
        axis_y  = 1'b1;
        state_d = S_MX;
      end
      S_MX:     state_d = S_DX_GO;
      S_DX_GO: begin
        div_start = 1'b1;
        use_decay = 1'b1;
        state_d   = S_DX_RUN;
      end
      S_DX_RUN: if (div_done) state_d = S_MY;
      S_MY: begin
        axis_y  = 1'b1;
        state_d = S_DY_GO;
      end
      S_DY_GO: begin
        axis_y    = 1'b1;
        div_start = 1'b1;
        use_decay = 1'b1;
        state_d   = S_DY_RUN;
      end
      S_DY_RUN: begin
        axis_y = 1'b1;
        if (div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!report) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Persistent state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      was_touch_q <= 1'b0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      carry_x_q   <= '0;
      carry_y_q   <= '0;
      last_btn_q  <= '0;
    end else begin
      case (state_q)
        S_VEL: begin
          if (touch_q) begin
            if (was_touch_q) begin
              vel_x_q <= vel_add(vel_x_q, px_q, last_x_q);
              vel_y_q <= vel_add(vel_y_q, py_q, last_y_q);
            end
            last_x_q <= px_q;
            last_y_q <= py_q;
          end
          was_touch_q <= touch_q;
        end
        S_QX_FIN: carry_x_q <= carry_new;
        S_QY_FIN: carry_y_q <= carry_new;
        S_DX_RUN: if (div_done) vel_x_q <= vel_decay;
        S_DY_RUN: if (div_done) vel_y_q <= vel_decay;
        S_EMIT:   if (out_load) last_btn_q <= btn_q;
        default: ;
      endcase
    end
  end

  // Sample capture and intermediate results
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      touch_q <= pad_touch_i;
      px_q    <= pad_x_i;
      py_q    <= pad_y_i;
      btn_q   <= {other_click_i, pad_click_i};
    end
    if ((state_q == S_QX_RUN || state_q == S_QY_RUN) && div_done) begin
      t_q <= t_next;
    end
    if (state_q == S_QX_FIN) mvx_q <= move_new;
    if (state_q == S_QY_FIN) mvy_q <= move_new;
    if (state_q == S_MX || state_q == S_MY) begin
      prod_q <= DIV_NUM_W'(mul_res);
    end
    if (out_load) begin
      out_btn_q <= btn_q;
      out_x_q   <= mvx_q;
      out_y_q   <= mvy_q;
    end
  end

  // Report valid: set on load, cleared by a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mouse_buttons_o = out_btn_q;
  assign move_x_o        = out_x_q;
  assign move_y_o        = out_y_q;

endmodule

[rtl/tgm_checker.sv]
// Port-level checks for the trackpad glide mouse core, bound to the top.
// Depends on tgm_pkg and trackpad_glide_mouse_core_macros.svh.
`include "trackpad_glide_mouse_core_macros.svh"

module tgm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [tgm_pkg::BTN_W-1:0]          mouse_buttons_o,
  input logic signed [tgm_pkg::MOVE_W-1:0]  move_x_o,
  input logic signed [tgm_pkg::MOVE_W-1:0]  move_y_o
);

  // Core is busy right after taking a sample
  `TGM_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // Moves are clamped to +-127, never the most negative code
  `TGM_ASSERT_NOW(a_move_range, out_valid_o, move_x_o != 8'h80 && move_y_o != 8'h80)

  // A new report only appears out of sample processing
  `TGM_ASSERT_NOW(a_report_from_work, $rose(out_valid_o), $past(in_stall_o))

  // Stalled report holds
  `TGM_ASSERT_NEXT(a_stalled_holds, out_valid_o && out_stall_i, out_valid_o && $stable(move_x_o) && $stable(move_y_o) && $stable(mouse_buttons_o))

endmodule

bind trackpad_glide_mouse_core tgm_checker u_tgm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .mouse_buttons_o (mouse_buttons_o),
  .move_x_o        (move_x_o),
  .move_y_o        (move_y_o)
);
